// ----- sv/cross_blur_filter_core_assert.svh -----
// assertion macros for the cross blur filter core
`ifndef CROSS_BLUR_FILTER_CORE_ASSERT_SVH
`define CROSS_BLUR_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CBF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cross blur filter assertion failed");
`define CBF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cross blur filter assertion failed");
`else
`define CBF_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define CBF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- sv/cbf_pkg.sv -----
package cbf_pkg;

    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd1024;

    localparam int MEAN_TAPS  = 5;
    localparam int ROUND_BIAS = 2;

    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = 2;
    localparam int OUT_CNT_BITS = 3;

    typedef struct packed {
        logic push_above;
        logic push_self;
        logic row_end;
        logic frame_end;
    } t_push;

endpackage

// ----- sv/cbf_line_store.sv -----
module cbf_line_store #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr_next,
    input  logic [PIXEL_BITS-1:0]         i_wr_pixel,
    input  logic                          i_old_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_old_wr_addr,
    input  logic [PIXEL_BITS-1:0]         i_old_wr_data,
    output logic [PIXEL_BITS-1:0]         o_centre,
    output logic [PIXEL_BITS-1:0]         o_right,
    output logic [PIXEL_BITS-1:0]         o_up
);

    logic [PIXEL_BITS-1:0] r_prev_mem  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_older_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_centre;
    logic [PIXEL_BITS-1:0] r_right;
    logic [PIXEL_BITS-1:0] r_up;

    // previous row: two reads, write of the new pixel at the same column
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_centre             <= r_prev_mem[i_rd_addr];
            r_right              <= r_prev_mem[i_rd_addr_next];
            r_prev_mem[i_rd_addr] <= i_wr_pixel;
        end
    end

    // older row: takes the previous row entry in the cycle after it is read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up <= r_older_mem[i_rd_addr];
        end
        if (i_old_wr_en) begin
            r_older_mem[i_old_wr_addr] <= i_old_wr_data;
        end
    end

    assign o_centre = r_centre;
    assign o_right  = r_right;
    assign o_up     = r_up;

endmodule

// ----- sv/cbf_out_fifo.sv -----
module cbf_out_fifo #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cbf_pkg::t_push                   i_push,
    input  logic [PIXEL_BITS-1:0]            i_above_pixel,
    input  logic [PIXEL_BITS-1:0]            i_self_pixel,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [PIXEL_BITS-1:0]            o_pixel,
    output logic                             o_row_end,
    output logic                             o_frame_end,
    output logic [cbf_pkg::OUT_CNT_BITS-1:0] o_count
);

    import cbf_pkg::*;

    logic [PIXEL_BITS-1:0]   r_pix_q [OUT_DEPTH];
    logic                    r_re_q  [OUT_DEPTH];
    logic                    r_fe_q  [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] r_wptr;
    logic [OUT_PTR_BITS-1:0] r_rptr;
    logic [OUT_CNT_BITS-1:0] r_count;
    logic [OUT_PTR_BITS-1:0] n_wptr;
    logic [OUT_CNT_BITS-1:0] n_count;
    logic [OUT_PTR_BITS-1:0] w_self_ptr;
    logic [1:0]              w_push_n;
    logic                    w_pop;

    always_comb begin
        w_push_n   = 2'(i_push.push_above) + 2'(i_push.push_self);
        w_self_ptr = i_push.push_above ? r_wptr + OUT_PTR_BITS'(1) : r_wptr;
        w_pop      = (r_count != '0) && !i_stall;
        n_wptr     = r_wptr + OUT_PTR_BITS'(w_push_n);
        n_count    = r_count + OUT_CNT_BITS'(w_push_n) - OUT_CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_above) begin
            r_pix_q[r_wptr] <= i_above_pixel;
            r_re_q[r_wptr]  <= i_push.row_end;
            r_fe_q[r_wptr]  <= 1'b0;
        end
        if (i_push.push_self) begin
            r_pix_q[w_self_ptr] <= i_self_pixel;
            r_re_q[w_self_ptr]  <= i_push.row_end;
            r_fe_q[w_self_ptr]  <= i_push.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (w_pop) begin
                r_rptr <= r_rptr + OUT_PTR_BITS'(1);
            end
        end
    end

    assign o_valid     = (r_count != '0);
    assign o_pixel     = r_pix_q[r_rptr];
    assign o_row_end   = r_re_q[r_rptr];
    assign o_frame_end = r_fe_q[r_rptr];
    assign o_count     = r_count;

endmodule

// ----- sv/cross_blur_filter_core.sv -----
// five-point cross mean blur over a gray frame streamed in raster order
// input channel: i_in_valid / o_in_stall with i_pixel_in, one pixel per transfer
// output channel: o_out_valid / i_out_stall with o_pixel_out, o_row_end, o_frame_end
// config: i_cfg_we with i_cfg_index (0 frame width, 1 frame height) and i_cfg_data;
//   a write restarts the frame, line store contents are kept
// output lags one row: the first row gives nothing, each later pixel gives the
//   pixel above it, and a last-row pixel also gives itself right after
// results of a pixel are formed from the accept stage registers and pushed to the
//   output queue together; a second result is queued right behind the first
// throughput: one pixel per cycle while the receiver takes a result every cycle;
//   a later last-row pixel gives two results, and the output moves one result a cycle
// frames of width or height two or less pass through unchanged
// reset clears counters, pipeline and output queue and sets both sizes to 1024;
//   the line stores are not cleared and need no clearing pass
// o_in_stall rises when the four-entry output queue has no room for two more
//   results beside those of the pixel in flight, so a stalled receiver holds the input
`include "cross_blur_filter_core_assert.svh"
module cross_blur_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [PIXEL_BITS-1:0]             i_pixel_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [PIXEL_BITS-1:0]             o_pixel_out,
    output logic                              o_row_end,
    output logic                              o_frame_end,
    input  logic                              i_cfg_we,
    input  logic [cbf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [cbf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    import cbf_pkg::*;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WID_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int SUM_BITS   = PIXEL_BITS + 3;
    localparam int SHIFT      = SUM_BITS + 3;
    localparam int PROD_BITS  = SUM_BITS + SHIFT;
    localparam logic [SHIFT-1:0] RECIP =
        SHIFT'(((64'd1 << SHIFT) + MEAN_TAPS - 1) / MEAN_TAPS);

    logic [WIDTH_REG_BITS-1:0]  r_frame_width;
    logic [HEIGHT_REG_BITS-1:0] r_frame_height;
    logic [COL_BITS-1:0]        r_col;
    logic [HEIGHT_REG_BITS-1:0] r_row;
    logic [COL_BITS-1:0]        n_col;
    logic [HEIGHT_REG_BITS-1:0] n_row;

    logic [WID_BITS-1:0]        w_width_eff;
    logic [HEIGHT_REG_BITS-1:0] w_height_eff;
    logic [COL_BITS-1:0]        w_col;
    logic [COL_BITS-1:0]        w_col_next;
    logic                       w_last_col;
    logic                       w_last_row;
    logic                       w_blur_ok;
    logic                       w_interior;
    logic                       w_accept;
    logic [1:0]                 w_a_results;

    logic                       r_a_valid;
    logic [PIXEL_BITS-1:0]      r_a_pix;
    logic [COL_BITS-1:0]        r_a_col;
    logic                       r_a_above;
    logic                       r_a_interior;
    logic                       r_a_last_col;
    logic                       r_a_last_row;
    logic [PIXEL_BITS-1:0]      r_left;

    logic [PIXEL_BITS-1:0]      w_centre;
    logic [PIXEL_BITS-1:0]      w_right;
    logic [PIXEL_BITS-1:0]      w_up;
    logic [SUM_BITS-1:0]        w_sum;
    logic [PROD_BITS-1:0]       w_prod;
    logic [PIXEL_BITS-1:0]      w_above_pixel;
    t_push                      w_push;
    logic [OUT_CNT_BITS-1:0]    w_fifo_count;

    always_comb begin
        if (r_frame_width == '0) begin
            w_width_eff = WID_BITS'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_width_eff = WID_BITS'(MAX_WIDTH);
        end else begin
            w_width_eff = WID_BITS'(r_frame_width);
        end
        w_height_eff = (r_frame_height == '0) ? HEIGHT_REG_BITS'(1) : r_frame_height;

        w_col      = (WID_BITS'(r_col) >= w_width_eff) ? '0 : r_col;
        w_last_col = (WID_BITS'(w_col) + WID_BITS'(1) == w_width_eff);
        w_last_row = ({1'b0, r_row} + 17'd1 == {1'b0, w_height_eff});
        w_blur_ok  = (w_width_eff > WID_BITS'(2)) && (w_height_eff > HEIGHT_REG_BITS'(2));
        w_interior = w_blur_ok && (r_row >= HEIGHT_REG_BITS'(2)) && (w_col != '0)
                     && !w_last_col;
        w_col_next = w_last_col ? '0 : w_col + COL_BITS'(1);

        if (w_last_col) begin
            n_col = '0;
            n_row = w_last_row ? '0 : r_row + HEIGHT_REG_BITS'(1);
        end else begin
            n_col = w_col + COL_BITS'(1);
            n_row = r_row;
        end

        w_a_results = r_a_valid ? (2'(r_a_above) + 2'(r_a_last_row)) : 2'd0;
        o_in_stall  = ({1'b0, w_fifo_count} + 4'(w_a_results) + 4'd2) > 4'(OUT_DEPTH);
        w_accept    = i_in_valid && !o_in_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[WIDTH_REG_BITS-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[HEIGHT_REG_BITS-1:0];
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_pix      <= i_pixel_in;
            r_a_col      <= w_col;
            r_a_above    <= (r_row != '0);
            r_a_interior <= w_interior;
            r_a_last_col <= w_last_col;
            r_a_last_row <= w_last_row;
        end
        if (r_a_valid) begin
            r_left <= w_centre;
        end
    end

    cbf_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_store (
        .i_clk          (i_clk),
        .i_rd_en        (w_accept),
        .i_rd_addr      (w_col),
        .i_rd_addr_next (w_col_next),
        .i_wr_pixel     (i_pixel_in),
        .i_old_wr_en    (r_a_valid),
        .i_old_wr_addr  (r_a_col),
        .i_old_wr_data  (w_centre),
        .o_centre       (w_centre),
        .o_right        (w_right),
        .o_up           (w_up)
    );

    // rounded mean of five by reciprocal multiply
    always_comb begin
        w_sum = SUM_BITS'(w_centre) + SUM_BITS'(w_up) + SUM_BITS'(r_left)
              + SUM_BITS'(w_right) + SUM_BITS'(r_a_pix) + SUM_BITS'(ROUND_BIAS);
        w_prod        = PROD_BITS'(w_sum) * PROD_BITS'(RECIP);
        w_above_pixel = r_a_interior ? w_prod[SHIFT +: PIXEL_BITS] : w_centre;

        w_push.push_above = r_a_valid && r_a_above;
        w_push.push_self  = r_a_valid && r_a_last_row;
        w_push.row_end    = r_a_last_col;
        w_push.frame_end  = r_a_last_col;
    end

    cbf_out_fifo #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_out_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_above_pixel (w_above_pixel),
        .i_self_pixel  (r_a_pix),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_pixel       (o_pixel_out),
        .o_row_end     (o_row_end),
        .o_frame_end   (o_frame_end),
        .o_count       (w_fifo_count)
    );

    `CBF_ASSERT_ALWAYS(a_fifo_bound, i_clk, i_rst_n, w_fifo_count <= OUT_CNT_BITS'(OUT_DEPTH))
    `CBF_ASSERT_ALWAYS(a_full_stalls, i_clk, i_rst_n, (w_fifo_count != OUT_CNT_BITS'(OUT_DEPTH)) || o_in_stall)
    `CBF_ASSERT_NEXT(a_accept_stage, i_clk, i_rst_n, w_accept, r_a_valid)

endmodule

// ----- test/cbf_checker.sv -----
module cbf_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [PIXEL_BITS-1:0]               i_pixel_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [PIXEL_BITS-1:0]               i_pixel_out,
    input  logic                                i_row_end,
    input  logic                                i_frame_end,
    input  logic                                i_cfg_we,
    input  logic [cbf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [cbf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_check_end,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_results
);
    import cbf_pkg::*;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  row_end;
        logic                  frame_end;
    } t_blur_pixel;

    t_blur_pixel                  blurred_q[$];
    logic [WIDTH_REG_BITS-1:0]    frame_width  = WIDTH_RESET;
    logic [HEIGHT_REG_BITS-1:0]   frame_height = HEIGHT_RESET;
    int unsigned                  col_idx = 0;
    int unsigned                  row_idx = 0;
    logic [PIXEL_BITS-1:0]        prev_line  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]        older_line [MAX_WIDTH];

    task automatic report_mismatch(input string msg);
        if (o_errors < 100) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        o_errors++;
    endtask

    // blur of the pixel above the incoming one, then the pixel itself on the last row
    task automatic predict_blur(input logic [PIXEL_BITS-1:0] pix);
        int unsigned           w;
        int unsigned           h;
        int unsigned           c;
        int unsigned           r;
        int unsigned           sum;
        logic                  blur_ok;
        logic                  last_col;
        logic                  last_row;
        logic [PIXEL_BITS-1:0] above;
        w = (frame_width == 0) ? 1 : (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
        h = (frame_height == 0) ? 1 : frame_height;
        c = col_idx;
        r = row_idx;
        blur_ok  = (w > 2) && (h > 2);
        last_col = (c + 1 == w);
        last_row = (r + 1 == h);
        if (c >= w) begin
            c = 0;
        end
        if (r >= 1) begin
            above = prev_line[c];
            if (blur_ok && r >= 2 && c >= 1 && !last_col) begin
                sum = 32'(prev_line[c]) + 32'(older_line[c]) + 32'(older_line[c-1])
                    + 32'(prev_line[c+1]) + 32'(pix);
                above = PIXEL_BITS'((sum + ROUND_BIAS) / MEAN_TAPS);
            end
            blurred_q.push_back('{above, last_col, 1'b0});
        end
        older_line[c] = prev_line[c];
        prev_line[c]  = pix;
        if (last_row) begin
            blurred_q.push_back('{pix, last_col, last_col});
        end
        if (last_col) begin
            col_idx = 0;
            row_idx = last_row ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            col_idx = c + 1;
        end
    endtask

    task automatic check_transfer();
        t_blur_pixel want;
        o_results++;
        if (blurred_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %0d", i_pixel_out));
        end else begin
            want = blurred_q.pop_front();
            if (i_pixel_out !== want.pixel) begin
                report_mismatch($sformatf("pixel_out %0d, want %0d", i_pixel_out, want.pixel));
            end
            if (i_row_end !== want.row_end) begin
                report_mismatch($sformatf("row_end %b, want %b", i_row_end, want.row_end));
            end
            if (i_frame_end !== want.frame_end) begin
                report_mismatch($sformatf("frame_end %b, want %b", i_frame_end, want.frame_end));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blurred_q.delete();
            frame_width  = WIDTH_RESET;
            frame_height = HEIGHT_RESET;
            col_idx = 0;
            row_idx = 0;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                prev_line[i]  = '0;
                older_line[i] = '0;
            end
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_transfer();
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    frame_width = i_cfg_data[WIDTH_REG_BITS-1:0];
                end else begin
                    frame_height = i_cfg_data[HEIGHT_REG_BITS-1:0];
                end
                col_idx = 0;
                row_idx = 0;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_blur(i_pixel_in);
            end
            if (i_check_end) begin
                while (blurred_q.size() != 0) begin
                    report_mismatch($sformatf("pixel %0d never arrived", blurred_q[0].pixel));
                    void'(blurred_q.pop_front());
                end
            end
        end
        o_pending = blurred_q.size();
    end

endmodule

// ----- test/tb_cross_blur_filter_core.sv -----
module tb_cross_blur_filter_core;
    import cbf_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int TOTAL_PIXELS = 1300;
    localparam int WIDE_PIXELS  = 1024 + 32;

    logic                        clk;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic [7:0]                  pixel_in   = '0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic [7:0]                  pixel_out;
    logic                        row_end;
    logic                        frame_end;
    logic                        cfg_we     = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index  = CFG_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0]    cfg_data   = '0;
    logic                        check_end  = 1'b0;
    int                          errors;
    int                          pending;
    int                          results;
    int                          send_gap_pct = 0;
    int                          stall_pct    = 0;
    int                          pixels_sent  = 0;
    int                          settings     = 0;
    logic [7:0]                  fixed_pixels[$];

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    cross_blur_filter_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_pixel_in  (pixel_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_pixel_out (pixel_out),
        .o_row_end   (row_end),
        .o_frame_end (frame_end),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cbf_checker u_blur_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_pixel_in  (pixel_in),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_pixel_out (pixel_out),
        .i_row_end   (row_end),
        .i_frame_end (frame_end),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_check_end (check_end),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic wait_idle();
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] pix);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
        pixels_sent++;
    endtask

    // fixed pixels are used first, random ones after
    task automatic run_phase(input logic [15:0] width_val, input logic [15:0] height_val,
                             input int count, input t_idle_mode mode);
        wait_idle();
        send_gap_pct = (mode == IDLE_SENDER) ? 57 : (mode == IDLE_BOTH) ? 13 : 0;
        stall_pct    = (mode == IDLE_RECEIVER) ? 57 : (mode == IDLE_BOTH) ? 13 : 0;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= width_val;
        @(negedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= height_val;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings++;
        for (int i = 0; i < count; i++) begin
            if (fixed_pixels.size() != 0) begin
                send_pixel(fixed_pixels.pop_front());
            end else begin
                send_pixel(8'($urandom_range(255)));
            end
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        int         pick;
        int         eff_w;
        int         eff_h;
        int         frame_px;
        int         count;
        logic [15:0] width_val;
        logic [15:0] height_val;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // interior rounding up from remainders of four and three, borders passed
        fixed_pixels = '{8'd0, 8'd1, 8'd2, 8'd255,
                         8'd2, 8'd3, 8'd4, 8'd0,
                         8'd255, 8'd4, 8'd4, 8'd0};
        run_phase(16'd4, 16'd3, 12, IDLE_NONE);
        // single row: each pixel comes back by itself
        fixed_pixels = '{8'd255, 8'd0, 8'd128, 8'd1};
        run_phase(16'd4, 16'd1, 4, IDLE_NONE);
        // zero sizes act as one by one
        fixed_pixels = '{8'd7, 8'd200};
        run_phase(16'd0, 16'd0, 2, IDLE_RECEIVER);
        // narrow frame passes through
        run_phase(16'd2, 16'd4, 8, IDLE_SENDER);

        while (pixels_sent + WIDE_PIXELS < TOTAL_PIXELS) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                width_val = 16'd0;
            end else if (pick < 10) begin
                width_val = 16'($urandom_range(2047, 1025));
            end else if (pick < 15) begin
                width_val = 16'($urandom_range(2, 1));
            end else begin
                width_val = 16'($urandom_range(14, 3));
            end
            eff_w = (width_val == 0) ? 1 : (width_val > 1024) ? 1024 : width_val;
            width_val = width_val | 16'($urandom_range(31) << WIDTH_REG_BITS);
            pick = $urandom_range(99);
            if (pick < 8) begin
                height_val = 16'd0;
            end else if (pick < 16) begin
                height_val = 16'($urandom_range(2, 1));
            end else if (pick < 90) begin
                height_val = 16'($urandom_range(10, 3));
            end else begin
                height_val = 16'($urandom_range(65535, 11));
            end
            eff_h = (height_val == 0) ? 1 : height_val;
            frame_px = eff_w * eff_h;
            if (frame_px > 300 || $urandom_range(99) < 20) begin
                count = $urandom_range((frame_px > 300) ? 300 : frame_px, 1);
            end else begin
                count = frame_px * $urandom_range(3, 1);
            end
            run_phase(width_val, height_val, count, t_idle_mode'(settings % 4));
        end

        // widest rows on the tallest frame, left unfinished in the second row
        run_phase(16'd1024, 16'hFFFF, WIDE_PIXELS, IDLE_BOTH);

        stall_pct = 0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        check_end <= 1'b1;
        @(negedge clk);
        check_end <= 1'b0;
        @(negedge clk);

        $display("%0d frame settings, %0d pixels sent, %0d output pixels compared",
                 settings, pixels_sent, results);
        $display("sizes 0..2047 wide and 0..65535 high, under sender gaps and receiver stalls");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- cross_blur_filter_core.f -----
+incdir+sv
sv/cbf_pkg.sv
sv/cbf_line_store.sv
sv/cbf_out_fifo.sv
sv/cross_blur_filter_core.sv
test/cbf_checker.sv
test/tb_cross_blur_filter_core.sv
